// ===== design/scov_pkg.sv =====
`default_nettype none
package scov_pkg;

  // exponential table size
  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);
  localparam int FN_W = 40 + IDX_W;

  // 2*log2(e) in Q.28 and ln(2) in Q.32
  localparam logic [29:0] EXP_K = 30'd774541002;
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  // pipeline depth in register stages
  localparam int NSTG = 7;
  localparam int NENT = 6;

  // row pairs of the six distinct covariance entries: xx xy xz yy yz zz
  localparam int EI [NENT] = '{0, 0, 0, 1, 1, 2};
  localparam int EJ [NENT] = '{0, 1, 2, 1, 2, 2};

  typedef logic [NSTG-1:0] stage_en_t;
  typedef logic [33:0] exp_ent_t;
  typedef exp_ent_t exp_tab_t [EXP_TABLE_ENTRIES+1];
  typedef logic [48:0] sq_t;
  typedef sq_t sq_arr_t [3];
  typedef logic signed [63:0] prod_t;
  typedef prod_t prod_arr_t [NENT][3];
  typedef logic signed [47:0] cov_t;
  typedef cov_t cov_arr_t [NENT];

  // 2^(i/N) in Q.32 by a truncated Taylor series of exp
  function automatic exp_ent_t pow2_entry(int unsigned i);
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    if (i >= EXP_TABLE_ENTRIES) begin
      return 34'h2_0000_0000;
    end
    x = (64'(i) * LN2_Q32) / 64'(EXP_TABLE_ENTRIES);
    sum = 64'h1_0000_0000;
    term = 64'h1_0000_0000;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * x) >> 32) / 64'(k);
      sum = sum + term;
    end
    return sum[33:0];
  endfunction

  function automatic exp_tab_t exp_tab_build();
    exp_tab_t t;
    for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
      t[i] = pow2_entry(i);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_tab_build();

endpackage
`default_nettype wire

// ===== design/scov_if.sv =====
`default_nettype none
interface scov_splat_if;
  logic valid;
  logic ready;
  logic signed [15:0] log_scale_x;
  logic signed [15:0] log_scale_y;
  logic signed [15:0] log_scale_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source(output valid, log_scale_x, log_scale_y, log_scale_z,
                 quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, log_scale_x, log_scale_y, log_scale_z,
               quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface scov_cov_if;
  logic valid;
  logic ready;
  logic signed [47:0] cov_xx;
  logic signed [47:0] cov_xy;
  logic signed [47:0] cov_xz;
  logic signed [47:0] cov_yy;
  logic signed [47:0] cov_yz;
  logic signed [47:0] cov_zz;

  modport source(output valid, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz,
                 input ready);
  modport sink(input valid, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz,
               output ready);
endinterface
`default_nettype wire

// ===== design/scov_exp.sv =====
`default_nettype none
module scov_exp import scov_pkg::*; (
  input  wire logic               clk,
  input  wire stage_en_t          en,
  input  wire logic signed [15:0] log_scale,
  output sq_t                     s2
);

  logic signed [46:0]   u_prod;
  logic signed [46:0]   u;
  logic [47:0]          ub;
  logic [FN_W-1:0]      fn;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W:0]       idx_n;
  logic [33:0]          a_tab;
  logic [33:0]          b_tab;

  logic [6:0]           nb2;
  logic [33:0]          a2;
  logic [33:0]          d2;
  logic [23:0]          rem2;

  logic [57:0]          ip_prod;
  logic [6:0]           nb3;
  logic [33:0]          a3;
  logic [33:0]          ip3;

  logic [34:0]          mant;
  logic [63:0]          m64;
  logic [63:0]          rnd;
  logic [5:0]           sh;
  sq_t                  s2_next;

  assign u_prod = log_scale * $signed({1'b0, EXP_K});

  // biased so that the integer part is positive: bits 46:40 hold n + 64
  always_comb begin
    ub    = {u[46], u} + 48'h4000_0000_0000;
    fn    = FN_W'(ub[39:0]) * FN_W'(EXP_TABLE_ENTRIES);
    idx   = fn[FN_W-1:40];
    idx_n = {1'b0, idx} + 1'b1;
    a_tab = EXP_TAB[idx];
    b_tab = EXP_TAB[idx_n];
  end

  assign ip_prod = d2 * rem2;

  always_comb begin
    mant = {1'b0, a3} + {1'b0, ip3};
    m64  = 64'(mant);
    sh   = '0;
    rnd  = '0;
    if (nb3 >= 7'd72) begin
      s2_next = 49'(m64 << (nb3 - 7'd72));
    end else begin
      sh      = 6'(7'd72 - nb3);
      rnd     = 64'd1 << (sh - 6'd1);
      s2_next = 49'((m64 + rnd) >> sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u <= u_prod;
    end
    if (en[1]) begin
      nb2  <= ub[46:40];
      a2   <= a_tab;
      d2   <= b_tab - a_tab;
      rem2 <= fn[39:16];
    end
    if (en[2]) begin
      nb3 <= nb2;
      a3  <= a2;
      ip3 <= ip_prod[57:24];
    end
    if (en[3]) begin
      s2 <= s2_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/scov_rot.sv =====
`default_nettype none
module scov_rot import scov_pkg::*; (
  input  wire logic               clk,
  input  wire stage_en_t          en,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  output prod_arr_t               prod
);

  localparam logic signed [33:0] ONE = 34'sd134217728;

  logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [33:0] rn [3][3];
  logic signed [33:0] rm [3][3];
  logic signed [67:0] pn [NENT][3];
  prod_arr_t          p3;

  // matrix in Q.27: the factor two of the usual formula is folded in
  always_comb begin
    rn[0][0] = ONE - (34'(yy) + 34'(zz));
    rn[0][1] = 34'(xy) - 34'(wz);
    rn[0][2] = 34'(xz) + 34'(wy);
    rn[1][0] = 34'(xy) + 34'(wz);
    rn[1][1] = ONE - (34'(xx) + 34'(zz));
    rn[1][2] = 34'(yz) - 34'(wx);
    rn[2][0] = 34'(xz) - 34'(wy);
    rn[2][1] = 34'(yz) + 34'(wx);
    rn[2][2] = ONE - (34'(xx) + 34'(yy));
  end

  always_comb begin
    for (int e = 0; e < NENT; e++) begin
      for (int k = 0; k < 3; k++) begin
        pn[e][k] = rm[EI[e]][k] * rm[EJ[e]][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xx <= quat_x * quat_x;
      yy <= quat_y * quat_y;
      zz <= quat_z * quat_z;
      xy <= quat_x * quat_y;
      xz <= quat_x * quat_z;
      yz <= quat_y * quat_z;
      wx <= quat_w * quat_x;
      wy <= quat_w * quat_y;
      wz <= quat_w * quat_z;
    end
    if (en[1]) begin
      rm <= rn;
    end
    for (int e = 0; e < NENT; e++) begin
      for (int k = 0; k < 3; k++) begin
        if (en[2]) begin
          p3[e][k] <= pn[e][k][63:0];
        end
        // wait for the squared scales
        if (en[3]) begin
          prod[e][k] <= p3[e][k];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/scov_mac.sv =====
`default_nettype none
module scov_mac import scov_pkg::*; (
  input  wire logic      clk,
  input  wire stage_en_t en,
  input  wire prod_arr_t prod,
  input  wire sq_arr_t   s2,
  output cov_arr_t       cov
);

  // product split into 32-bit halves, scale into 25 + 24 bits
  logic [56:0]         pll [NENT][3];
  logic [55:0]         plh [NENT][3];
  logic signed [57:0]  phl [NENT][3];
  logic signed [56:0]  phh [NENT][3];
  logic [56:0]         pll_n [NENT][3];
  logic [55:0]         plh_n [NENT][3];
  logic signed [57:0]  phl_n [NENT][3];
  logic signed [56:0]  phh_n [NENT][3];
  logic [127:0]        term_n [NENT][3];
  logic [127:0]        term [NENT][3];
  logic [127:0]        acc [NENT];
  cov_t                cov_next [NENT];

  always_comb begin
    for (int e = 0; e < NENT; e++) begin
      for (int k = 0; k < 3; k++) begin
        pll_n[e][k] = prod[e][k][31:0] * s2[k][24:0];
        plh_n[e][k] = prod[e][k][31:0] * s2[k][48:25];
        phl_n[e][k] = $signed(prod[e][k][63:32]) * $signed({1'b0, s2[k][24:0]});
        phh_n[e][k] = $signed(prod[e][k][63:32]) * $signed({1'b0, s2[k][48:25]});
      end
    end
  end

  always_comb begin
    for (int e = 0; e < NENT; e++) begin
      for (int k = 0; k < 3; k++) begin
        term_n[e][k] = 128'(pll[e][k]) + (128'(plh[e][k]) << 25)
                     + (128'(phl[e][k]) << 32) + (128'(phh[e][k]) << 57);
      end
    end
  end

  // sum in Q.78, round half up to Q.24, clamp to 48 bits
  always_comb begin
    for (int e = 0; e < NENT; e++) begin
      acc[e] = term[e][0] + term[e][1] + term[e][2] + (128'd1 << 53);
      if ((&acc[e][127:101]) || !(|acc[e][127:101])) begin
        cov_next[e] = acc[e][101:54];
      end else if (acc[e][127]) begin
        cov_next[e] = {1'b1, 47'd0};
      end else begin
        cov_next[e] = {1'b0, {47{1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < NENT; e++) begin
      for (int k = 0; k < 3; k++) begin
        if (en[4]) begin
          pll[e][k] <= pll_n[e][k];
          plh[e][k] <= plh_n[e][k];
          phl[e][k] <= phl_n[e][k];
          phh[e][k] <= phh_n[e][k];
        end
        if (en[5]) begin
          term[e][k] <= term_n[e][k];
        end
      end
      if (en[6]) begin
        cov[e] <= cov_next[e];
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/splat_covariance_from_scale_rotation.sv =====
`default_nettype none
// Covariance of one 3D Gaussian splat per transaction: three Q4.12 log scales
// and a Q2.14 quaternion (taken as given, not normalised) in, the six distinct
// entries of R*diag(s^2)*R^T out as saturated Q24.24. Seven register stages;
// one splat is taken every cycle while the output side keeps up. Each stage
// holds its own valid bit and loads whenever it is empty or the stage after it
// moves, so bubbles close up and a stalled output still lets upstream stages
// fill. The squared scales come from a constant 2^(i/N) table with linear
// interpolation.
module splat_covariance_from_scale_rotation import scov_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  scov_splat_if.sink   splat,
  scov_cov_if.source   cov
);

  stage_en_t  en;
  logic [NSTG-1:0] vld;
  sq_arr_t    s2;
  prod_arr_t  prod;
  cov_arr_t   ent;

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || cov.ready;
    for (int s = NSTG - 2; s >= 0; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end

  assign splat.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= splat.valid;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (en[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  scov_exp u_exp_x (.clk(clk), .en(en), .log_scale(splat.log_scale_x), .s2(s2[0]));
  scov_exp u_exp_y (.clk(clk), .en(en), .log_scale(splat.log_scale_y), .s2(s2[1]));
  scov_exp u_exp_z (.clk(clk), .en(en), .log_scale(splat.log_scale_z), .s2(s2[2]));

  scov_rot u_rot (
    .clk(clk), .en(en),
    .quat_w(splat.quat_w), .quat_x(splat.quat_x),
    .quat_y(splat.quat_y), .quat_z(splat.quat_z),
    .prod(prod)
  );

  scov_mac u_mac (.clk(clk), .en(en), .prod(prod), .s2(s2), .cov(ent));

  assign cov.valid  = vld[NSTG-1];
  assign cov.cov_xx = ent[0];
  assign cov.cov_xy = ent[1];
  assign cov.cov_xz = ent[2];
  assign cov.cov_yy = ent[3];
  assign cov.cov_yz = ent[4];
  assign cov.cov_zz = ent[5];

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    cov.ready |-> splat.ready)
    else $error("input stalled while output side is ready");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (splat.valid && splat.ready && cov.ready) ##1 cov.ready ##1 cov.ready
      ##1 cov.ready ##1 cov.ready ##1 cov.ready ##1 cov.ready |=> cov.valid)
    else $error("accepted transaction did not reach the output");

  a_reset: assert property (@(posedge clk) rst |=> !cov.valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

// ===== tb/splat_covariance_from_scale_rotation_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

class cov_scoreboard;
  typedef logic signed [47:0] ent_t;
  typedef struct {
    ent_t e [6];
  } cov_rec_t;

  cov_rec_t pending [$];
  int errors;

  localparam longint KEXP = 64'd774541002;
  localparam int TABN = 256;
  longint unsigned tab [TABN+1];

  function new();
    longint unsigned x, sum, term;
    errors = 0;
    for (int i = 0; i <= TABN; i++) begin
      if (i == TABN) begin
        tab[i] = 64'h2_0000_0000;
      end else begin
        x = (64'(i) * 64'd2977044472) / 64'(TABN);
        sum = 64'h1_0000_0000;
        term = sum;
        for (int k = 1; k <= 24; k++) begin
          term = ((term * x) >> 32) / 64'(k);
          sum += term;
        end
        tab[i] = sum;
      end
    end
  endfunction

  function longint unsigned sq_scale(logic signed [15:0] lg);
    longint u;
    longint unsigned ub, f, fn, idx, rem, a, b, mant;
    int n, sh;
    u = longint'(lg) * KEXP;
    ub = 64'(u + (64'sd1 <<< 46));
    n = int'(ub >> 40) - 64;
    f = ub & 64'hFF_FFFF_FFFF;
    fn = f * 64'(TABN);
    idx = fn >> 40;
    rem = (fn & 64'hFF_FFFF_FFFF) >> 16;
    a = tab[idx];
    b = tab[idx+1];
    mant = a + (((b - a) * rem) >> 24);
    if (n >= 8) return mant << (n - 8);
    sh = 8 - n;
    if (sh >= 40) return 0;
    return (mant + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function ent_t entry(longint ri [3], longint rj [3], longint unsigned s2 [3]);
    logic signed [127:0] acc;
    logic signed [127:0] v;
    acc = 0;
    for (int k = 0; k < 3; k++)
      acc += 128'(ri[k] * rj[k]) * $signed({64'd0, s2[k]});
    acc += 128'sd1 <<< 53;
    v = acc >>> 54;
    if (v > 128'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -(128'sh8000_0000_0000)) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  function void note_splat(logic signed [15:0] ls [3], logic signed [15:0] q [4]);
    longint w, x, y, z, one;
    longint r [3][3];
    longint unsigned s2 [3];
    cov_rec_t c;
    int pi [6], pj [6];
    pi = '{0, 0, 0, 1, 1, 2};
    pj = '{0, 1, 2, 1, 2, 2};
    w = q[0]; x = q[1]; y = q[2]; z = q[3];
    one = 64'sd1 <<< 27;
    for (int k = 0; k < 3; k++) s2[k] = sq_scale(ls[k]);
    r[0] = '{one - (y*y + z*z), x*y - w*z, x*z + w*y};
    r[1] = '{x*y + w*z, one - (x*x + z*z), y*z - w*x};
    r[2] = '{x*z - w*y, y*z + w*x, one - (x*x + y*y)};
    for (int e = 0; e < 6; e++) c.e[e] = entry(r[pi[e]], r[pj[e]], s2);
    pending.push_back(c);
  endfunction

  function void check_cov(ent_t got [6]);
    cov_rec_t c;
    if (pending.size() == 0) begin
      $display("%0t: unexpected covariance transaction", $time);
      errors++;
      return;
    end
    c = pending.pop_front();
    for (int e = 0; e < 6; e++)
      if (got[e] !== c.e[e]) begin
        $display("%0t: entry %0d expected %h actual %h", $time, e, c.e[e], got[e]);
        errors++;
      end
  endfunction
endclass

module splat_covariance_from_scale_rotation_test;
  logic clk = 0;
  logic rst = 1;
  logic calm = 0;
  int quiet = 0;
  cov_scoreboard sb;

  scov_splat_if splat();
  scov_cov_if cov();

  splat_covariance_from_scale_rotation uut (.clk(clk), .rst(rst), .splat(splat), .cov(cov));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    splat.valid = 0;
    {splat.log_scale_x, splat.log_scale_y, splat.log_scale_z} = '0;
    {splat.quat_w, splat.quat_x, splat.quat_y, splat.quat_z} = '0;
    cov.ready = 0;
  end

  // checking and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cov.valid && cov.ready) begin
        sb.check_cov('{cov.cov_xx, cov.cov_xy, cov.cov_xz,
                       cov.cov_yy, cov.cov_yz, cov.cov_zz});
      end
      if ((splat.valid && splat.ready) || (cov.valid && cov.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 2000) begin
        $display("splat_covariance_from_scale_rotation_test failed");
        $finish;
      end
    end
  end

  // output stalls
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        cov.ready <= 0;
        n = $urandom_range(1, 17);
        repeat (n) @(posedge clk);
      end
      cov.ready <= 1;
    end
  end

  task automatic send_splat(logic signed [15:0] ls [3], logic signed [15:0] q [4]);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      splat.valid <= 0;
      n = $urandom_range(1, 17);
      repeat (n) @(posedge clk);
    end
    splat.valid <= 1;
    splat.log_scale_x <= ls[0];
    splat.log_scale_y <= ls[1];
    splat.log_scale_z <= ls[2];
    splat.quat_w <= q[0];
    splat.quat_x <= q[1];
    splat.quat_y <= q[2];
    splat.quat_z <= q[3];
    do @(posedge clk); while (!splat.ready);
    sb.note_splat(ls, q);
  endtask

  function automatic logic [15:0] rnd_field();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(0, 4000)) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [15:0] ls [3];
    logic signed [15:0] q [4];
    logic signed [15:0] ext [6];
    int tail;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    ext = '{16'sh8000, 16'sh7FFF, 0, -1, 16'sh4000, 16'shC000};
    // directed: identity, extremes, non-unit quaternions, tiny and huge scales
    foreach (ext[i]) begin
      ls = '{ext[i], ext[(i+1)%6], ext[(i+2)%6]};
      q = '{16'sh4000, 0, 0, 0};
      send_splat(ls, q);
      q = '{ext[i], ext[(i+3)%6], ext[(i+4)%6], ext[(i+5)%6]};
      send_splat(ls, q);
    end
    q = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    send_splat('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, q);
    q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    send_splat('{16'sh8000, 16'sh8000, 16'sh8000}, q);
    for (int i = 0; i < 550; i++) begin
      if (i == 450) calm = 1;
      foreach (ls[k]) ls[k] = rnd_field();
      if ($urandom_range(0, 1)) begin
        // small quaternion, each component in [-0.5, 0.5]
        foreach (q[k]) q[k] = 16'(int'($urandom_range(0, 16384)) - 8192);
      end else begin
        foreach (q[k]) q[k] = rnd_field();
      end
      send_splat(ls, q);
    end
    splat.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    tail = 0;
    while (tail < 20) begin
      @(posedge clk);
      tail++;
    end
    if (sb.errors == 0) $display("splat_covariance_from_scale_rotation_test passed");
    else $display("splat_covariance_from_scale_rotation_test failed");
    $finish;
  end
endmodule

`default_nettype wire
